// ----- sv/lpfr_pkg.sv -----
// package for the length-prefixed frame receiver
// holds shared constants and the structs passed between parser, buffer and top level
// no dependencies

package lpfr_pkg;

    localparam int MAX_FRAME_DEF = 256;
    localparam logic [7:0] START_BYTE = 8'h3C;

    localparam logic CMD_FEED = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic        we;
        logic [15:0] waddr;
        logic [7:0]  wdata;
        logic        re;
        logic [15:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic       done;
        logic [8:0] flen;
        logic       rd_hit;
    } t_res;

endpackage

// ----- sv/lpfr_ctrl.sv -----
// frame parser: start byte, little-endian length, payload count
// issues buffer write and read requests per accepted transfer
// depends on lpfr_pkg

module lpfr_ctrl #(
    parameter int MAX_FRAME = lpfr_pkg::MAX_FRAME_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_command,
    input  logic [7:0]        i_rx_byte,
    input  logic [7:0]        i_read_index,
    output lpfr_pkg::t_mem_req o_req,
    output lpfr_pkg::t_res     o_res
);
    import lpfr_pkg::*;

    localparam logic [16:0] MAX_W = 17'(MAX_FRAME);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_START,
        PH_LEN_LO,
        PH_PAYLOAD
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_length, n_length;
    logic [15:0] r_count, n_count;

    logic [15:0] len_hi;
    logic [15:0] cnt_inc;
    logic [15:0] len_sat;
    logic        feed;

    always_comb begin
        feed     = i_accept && (i_command == CMD_FEED);
        len_hi   = {i_rx_byte, r_length[7:0]};
        cnt_inc  = r_count + 16'd1;
        len_sat  = ({1'b0, r_length} > MAX_W) ? MAX_W[15:0] : r_length;

        n_phase  = r_phase;
        n_length = r_length;
        n_count  = r_count;

        o_req       = '0;
        o_req.wdata = i_rx_byte;
        o_req.waddr = r_count;
        o_req.raddr = {8'd0, i_read_index};
        o_res       = '0;

        if (i_command == CMD_READ) begin
            o_res.rd_hit = ({9'd0, i_read_index} < MAX_W);
            o_req.re     = i_accept && o_res.rd_hit;
        end

        if (feed) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_rx_byte == START_BYTE) begin
                        n_phase = PH_START;
                    end
                end
                PH_START: begin
                    n_length = {8'd0, i_rx_byte};
                    n_phase  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_length = len_hi;
                    n_count  = '0;
                    n_phase  = (len_hi != 16'd0) ? PH_PAYLOAD : PH_IDLE;
                end
                PH_PAYLOAD: begin
                    o_req.we = ({1'b0, r_count} < MAX_W);
                    n_count  = cnt_inc;
                    if (cnt_inc >= r_length) begin
                        n_length   = len_sat;
                        o_res.done = 1'b1;
                        o_res.flen = len_sat[8:0];
                        n_phase    = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_length <= '0;
            r_count  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_length <= n_length;
            r_count  <= n_count;
        end
    end

endmodule

// ----- sv/lpfr_buf.sv -----
// payload buffer: one write port, one read port, registered read data
// depends on lpfr_pkg for the request struct

module lpfr_buf #(
    parameter int MAX_FRAME = lpfr_pkg::MAX_FRAME_DEF
) (
    input  logic               i_clk,
    input  lpfr_pkg::t_mem_req i_req,
    output logic [7:0]         o_rdata
);
    import lpfr_pkg::*;

    localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;

    logic [7:0] r_mem [MAX_FRAME];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/length_prefixed_frame_receiver.sv -----
// Length-prefixed frame receiver. Takes one transfer per clock cycle when the
// output side keeps up; results come out in order, one result per input
// transfer, through the payload buffer's registered read port followed by the
// output register. tuser selects a feed (0, rx_byte is a link byte) or a buffer
// read (1, read_index picks the entry). A frame is '<', a 16-bit little-endian
// length, then that many payload bytes; bytes past MAX_FRAME are counted but
// not stored. tlast on the output marks the transfer that completed a frame,
// with its length saturated to MAX_FRAME.
// depends on lpfr_pkg, lpfr_ctrl, lpfr_buf

module length_prefixed_frame_receiver #(
    parameter int MAX_FRAME = lpfr_pkg::MAX_FRAME_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // rx_byte[7:0], read_index[15:8]
    input  logic        i_s_tuser,   // command[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // frame_length[8:0], read_data[16:9], zero pad
    output logic        o_m_tlast    // frame_done
);
    import lpfr_pkg::*;

    t_mem_req   req;
    t_res       res;
    logic [7:0] mem_rdata;
    logic       accept;
    logic       s1_adv;

    logic       r_s1_valid;
    t_res       r_s1_res;
    logic       r_o_valid;
    logic       r_o_done;
    logic [8:0] r_o_flen;
    logic [7:0] r_o_rdata;

    assign s1_adv     = !r_o_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || s1_adv;
    assign accept     = i_s_tvalid && o_s_tready;

    lpfr_ctrl #(.MAX_FRAME(MAX_FRAME)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_command    (i_s_tuser),
        .i_rx_byte    (i_s_tdata[7:0]),
        .i_read_index (i_s_tdata[15:8]),
        .o_req        (req),
        .o_res        (res)
    );

    lpfr_buf #(.MAX_FRAME(MAX_FRAME)) u_buf (
        .i_clk   (i_clk),
        .i_req   (req),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= r_s1_valid;
            end
        end
        if (accept) begin
            r_s1_res <= res;
        end
        if (s1_adv && r_s1_valid) begin
            r_o_done  <= r_s1_res.done;
            r_o_flen  <= r_s1_res.flen;
            r_o_rdata <= r_s1_res.rd_hit ? mem_rdata : 8'd0;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tlast  = r_o_done;
    assign o_m_tdata  = {7'd0, r_o_rdata, r_o_flen};

endmodule

// ----- sv/lpfr_chk.sv -----
// port-level checks for the length-prefixed frame receiver
// bound to length_prefixed_frame_receiver; no package dependency

module lpfr_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic        o_m_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled output transfer changed");

    a_len_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tdata[8:0] == 9'd0)
        else $error("frame length without completed frame");

    a_no_rdata_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tdata[16:9] == 8'd0 && o_m_tdata[23:17] == 7'd0)
        else $error("read data or pad set on a completed frame");

    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_tready && !o_m_tvalid)
        else $error("not ready or output valid right after reset");

endmodule

bind length_prefixed_frame_receiver lpfr_chk u_lpfr_chk (.*);

// ----- tb/sv/frame_rx_checker.sv -----
// checker for the length-prefixed frame receiver: predicts one result per input
// transfer and compares the output transfers against them in order
// depends on lpfr_pkg

module frame_rx_checker #(
    parameter int MAX_FRAME = lpfr_pkg::MAX_FRAME_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,   // rx_byte[7:0], read_index[15:8]
    input  logic        i_s_tuser,   // command[0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // frame_length[8:0], read_data[16:9], zero pad
    input  logic        i_m_tlast,   // frame_done
    output int          o_mismatches,
    output int          o_pending
);
    import lpfr_pkg::*;

    typedef enum logic [1:0] {
        WAIT_START,
        WAIT_LEN_LO,
        WAIT_LEN_HI,
        IN_PAYLOAD
    } t_rx_phase;

    typedef struct packed {
        logic       done;
        logic [8:0] flen;
        logic [7:0] rdata;
    } t_rx_result;

    t_rx_phase  rx_phase = WAIT_START;
    logic [15:0] frame_len = '0;
    logic [15:0] byte_count = '0;
    logic [7:0] payload [MAX_FRAME];
    t_rx_result results_due [$];
    int         mismatches = 0;

    function automatic t_rx_result rx_predict(logic cmd, logic [7:0] rx, logic [7:0] idx);
        t_rx_result r;
        r = '0;
        if (cmd == CMD_READ) begin
            if (idx < MAX_FRAME) r.rdata = payload[idx];
        end else begin
            case (rx_phase)
                WAIT_START: begin
                    if (rx == START_BYTE) rx_phase = WAIT_LEN_LO;
                end
                WAIT_LEN_LO: begin
                    frame_len = {8'h00, rx};
                    rx_phase = WAIT_LEN_HI;
                end
                WAIT_LEN_HI: begin
                    frame_len[15:8] = rx;
                    byte_count = '0;
                    rx_phase = (frame_len != 16'd0) ? IN_PAYLOAD : WAIT_START;
                end
                default: begin
                    if (byte_count < MAX_FRAME) payload[byte_count] = rx;
                    byte_count = byte_count + 16'd1;
                    if (byte_count >= frame_len) begin
                        // oversized frames report the buffer size
                        if (frame_len > MAX_FRAME) frame_len = 16'(MAX_FRAME);
                        r.done = 1'b1;
                        r.flen = frame_len[8:0];
                        rx_phase = WAIT_START;
                    end
                end
            endcase
        end
        return r;
    endfunction

    function automatic void report(string what, logic [15:0] want, logic [15:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch in %s at %0t: expected %0h, got %0h", what, $realtime, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_rx_result want;
        t_rx_result due;
        if (!i_rst_n) begin
            rx_phase = WAIT_START;
            frame_len = '0;
            byte_count = '0;
            results_due.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                due = rx_predict(i_s_tuser, i_s_tdata[7:0], i_s_tdata[15:8]);
                results_due = {results_due, due};
            end
            if (i_m_tvalid && i_m_tready) begin
                if (results_due.size() == 0) begin
                    report("transfer with no result due", 16'd0, 16'd1);
                end else begin
                    want = results_due.pop_front();
                    if (i_m_tlast !== want.done) begin
                        report("frame_done", 16'(want.done), 16'(i_m_tlast));
                    end
                    if (i_m_tdata[8:0] !== want.flen) begin
                        report("frame_length", 16'(want.flen), 16'(i_m_tdata[8:0]));
                    end
                    if (i_m_tdata[16:9] !== want.rdata) begin
                        report("read_data", 16'(want.rdata), 16'(i_m_tdata[16:9]));
                    end
                end
            end
        end
        o_mismatches <= mismatches;
        o_pending <= results_due.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
// top of the frame receiver testbench: clock, reset, byte and read stimulus,
// output-side stalls and the verdict
// depends on lpfr_pkg, length_prefixed_frame_receiver, frame_rx_checker

module testbench;
    import lpfr_pkg::*;

    localparam int MAX_FRAME = MAX_FRAME_DEF;
    localparam int ITEM_GOAL = 950;
    localparam int LONG_HOLD = 150;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;      // rx_byte[7:0], read_index[15:8]
    logic        s_tuser = 1'b0;    // command[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // frame_length[8:0], read_data[16:9], zero pad
    logic        m_tlast;           // frame_done
    int          mismatches;
    int          pending;

    int items_sent = 0;
    int burst_left = 0;
    int filled = 0;
    bit hold_asked = 1'b0;
    bit hold_done = 1'b0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    length_prefixed_frame_receiver dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    frame_rx_checker #(.MAX_FRAME(MAX_FRAME)) rx_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    task automatic put(logic cmd, logic [7:0] rx, logic [7:0] idx);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {idx, rx};
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic feed(logic [7:0] b);
        put(CMD_FEED, b, 8'($urandom));
    endtask

    task automatic read_at(logic [7:0] idx);
        put(CMD_READ, 8'($urandom), idx);
    endtask

    task automatic read_any();
        read_at(8'($urandom_range(0, filled - 1)));
    endtask

    // whole frame with random payload; with mix_reads, reads slipped in between payload bytes
    task automatic send_frame(int n, bit mix_reads);
        logic [15:0] len16;
        len16 = 16'(n);
        feed(START_BYTE);
        feed(len16[7:0]);
        feed(len16[15:8]);
        for (int i = 0; i < n; i++) begin
            if (mix_reads && filled > 0 && $urandom_range(0, 9) == 0) read_any();
            feed(8'($urandom));
        end
        if (n > filled) filled = (n > MAX_FRAME) ? MAX_FRAME : n;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // output side: segments of differing stall patterns, one long hold-off
    initial begin
        int mode;
        int seg;
        forever begin
            if (hold_asked && !hold_done) begin
                repeat (LONG_HOLD) begin
                    @(posedge clk);
                    m_tready <= 1'b0;
                end
                hold_done = 1'b1;
            end
            mode = $urandom_range(0, 3);
            seg = $urandom_range(20, 200);
            for (int k = 0; k < seg; k++) begin
                @(posedge clk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 5) == 0);
                    default: m_tready <= (k % 4 != 3);
                endcase
            end
        end
    end

    initial begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int pick;
        int big_done;
        bit drained;
        big_done = 0;
        drained = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // non-start bytes while idle are ignored
        feed(8'h00);
        feed(8'hFF);
        feed(8'h3D);
        // zero length goes straight back to idle
        feed(START_BYTE);
        feed(8'h00);
        feed(8'h00);
        feed(START_BYTE);
        feed(8'h01);
        feed(8'h00);
        feed(8'hFF);
        // start byte inside the payload is plain data
        feed(START_BYTE);
        feed(8'h03);
        feed(8'h00);
        feed(8'h00);
        feed(START_BYTE);
        feed(8'hAA);
        filled = 3;
        read_at(8'd0);
        read_at(8'd1);
        read_at(8'd2);
        // read in the middle of a frame leaves the parse alone
        feed(START_BYTE);
        feed(8'h02);
        feed(8'h00);
        feed(8'h55);
        read_at(8'd0);
        feed(8'h80);

        while (items_sent < ITEM_GOAL) begin
            pick = $urandom_range(0, 99);
            if (big_done == 0) begin
                send_frame(MAX_FRAME, 1'b0);
                big_done = 1;
            end else if (big_done == 1 && items_sent > 500) begin
                send_frame(MAX_FRAME + $urandom_range(1, 40), 1'b1);
                big_done = 2;
            end else if (pick < 8) begin
                pick = $urandom_range(0, 255);
                feed((pick == START_BYTE) ? 8'(pick ^ 1) : 8'(pick));
            end else if (pick < 22) begin
                repeat ($urandom_range(1, 4)) read_any();
            end else if (pick < 26) begin
                send_frame(0, 1'b0);
            end else begin
                send_frame($urandom_range(1, 16), 1'b1);
            end
            if (!hold_asked && items_sent > 300) hold_asked = 1'b1;
            if (!drained && items_sent > 650) begin
                drain();
                drained = 1'b1;
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
